/* hdl/dfsmg_pkg.sv */
// Shared widths, opcodes, status codes and register indexes of the maze generator.
package dfsmg_pkg;

	// field widths of the item, result and configuration channels
	localparam int OPCODE_W    = 2;
	localparam int DIR_W       = 2;
	localparam int COORD_W     = 5;
	localparam int STATUS_W    = 3;
	localparam int CFG_DATA_W  = 6;
	localparam int CFG_INDEX_W = 1;

	// untried-direction mask, one bit per direction
	localparam int         DIRS_W   = 4;
	localparam logic [3:0] ALL_DIRS = 4'hF;

	// item opcodes
	localparam logic [1:0] OP_INIT = 2'd0;
	localparam logic [1:0] OP_STEP = 2'd1;
	localparam logic [1:0] OP_READ = 2'd2;

	// directions
	localparam logic [1:0] DIR_RIGHT = 2'd0;
	localparam logic [1:0] DIR_DOWN  = 2'd1;
	localparam logic [1:0] DIR_LEFT  = 2'd2;
	localparam logic [1:0] DIR_UP    = 2'd3;

	// result status codes
	localparam logic [2:0] STAT_ACK       = 3'd0;
	localparam logic [2:0] STAT_NO_MOVE   = 3'd1;
	localparam logic [2:0] STAT_ADVANCED  = 3'd2;
	localparam logic [2:0] STAT_BACKTRACK = 3'd3;
	localparam logic [2:0] STAT_FINISHED  = 3'd4;

	// configuration register indexes and reset values
	localparam logic [0:0] REG_GRID_WIDTH  = 1'd0;
	localparam logic [0:0] REG_GRID_HEIGHT = 1'd1;
	localparam logic [5:0] GRID_DIM_RESET  = 6'd31;
	localparam int         GRID_DIM_MIN    = 3;

endpackage

/* hdl/dfsmg_if.sv */
// Item and result channel interfaces of the maze generator.
interface dfsmg_item_if;
	logic                              valid;
	logic                              ready;
	logic [dfsmg_pkg::OPCODE_W-1:0]    opcode;
	logic [dfsmg_pkg::DIR_W-1:0]       random_dir;
	logic [dfsmg_pkg::COORD_W-1:0]     cell_x;
	logic [dfsmg_pkg::COORD_W-1:0]     cell_y;

	modport source (output valid, output opcode, output random_dir, output cell_x,
		output cell_y, input ready);
	modport sink (input valid, input opcode, input random_dir, input cell_x,
		input cell_y, output ready);
endinterface

interface dfsmg_result_if;
	logic                              valid;
	logic                              ready;
	logic [dfsmg_pkg::STATUS_W-1:0]    step_status;
	logic [dfsmg_pkg::COORD_W-1:0]     current_x;
	logic [dfsmg_pkg::COORD_W-1:0]     current_y;
	logic                              cell_open;
	logic                              maze_done;

	modport source (output valid, output step_status, output current_x, output current_y,
		output cell_open, output maze_done, input ready);
	modport sink (input valid, input step_status, input current_x, input current_y,
		input cell_open, input maze_done, output ready);
endinterface

/* hdl/dfsmg_cell_ram.sv */
// Cell memory: one write port, one registered read port, reads as zero until first init.
module dfsmg_cell_ram #(
	parameter int DEPTH  = 1024,
	parameter int ADDR_W = 10,
	parameter int DATA_W = 16
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic [ADDR_W-1:0] raddr,
	input  logic              contents_valid,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [DEPTH];
	logic [DATA_W-1:0] rdata_s1;
	logic              valid_s1;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read, tagged with the contents-valid mark of its cycle
	always_ff @(posedge clk) begin
		rdata_s1 <= mem[raddr];
		valid_s1 <= contents_valid;
	end

	// before the first init every cell reads as its reset value (all zero)
	assign rdata = valid_s1 ? rdata_s1 : '0;

endmodule

/* hdl/dfs_maze_generator_core.sv */
// Maze generator top level: depth-first search with backtracking over a cell memory.
//
// Items arrive on the items channel (valid/ready); each item gives exactly one
// transaction on the results channel. The user writes grid width and height through
// cfg_we/cfg_index/cfg_wdata only while the block is idle, which the block does not
// enforce; values are clamped to 3..MAX_WIDTH and 3..MAX_HEIGHT when used.
// All per-cell state (open, untried directions, linked, parent) lives in one
// single-port-write, registered-read memory of MAX_WIDTH*MAX_HEIGHT entries.
// States an item passes before S_RESULT: none for an unused opcode; S_READ for a
//   cell read; S_CHK_CUR for a step decided at the current node (tried direction,
//   off the grid, backtrack, finish), adding S_CHK_TGT for a step blocked at its
//   target, and S_OPEN_MID too for a step that advances (target and wall writes
//   follow the current-node write); S_SWEEP for init, which writes every entry, one per cycle.
// The next item is taken in the cycle after the result is loaded, so a stalled
// receiver holds one result while the block works on the next item; a second
// result waits inside until the output register frees up.
// After reset the memory reads as all walls with no directions left (a
// validity mark, no clearing pass), the current node is (1,1) and the done
// flag is clear; the first step before any init therefore finishes.
module dfs_maze_generator_core #(
	parameter int MAX_WIDTH  = 32,
	parameter int MAX_HEIGHT = 32
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	dfsmg_item_if.sink                           items,
	dfsmg_result_if.source                       results,
	input  logic                                 cfg_we,
	input  logic [dfsmg_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [dfsmg_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

	localparam int XW      = $clog2(MAX_WIDTH);
	localparam int YW      = $clog2(MAX_HEIGHT);
	localparam int CELLS   = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW      = $clog2(CELLS);
	localparam int DW      = dfsmg_pkg::DIRS_W;
	localparam int CW      = dfsmg_pkg::COORD_W;
	localparam int SW      = dfsmg_pkg::STATUS_W;
	localparam int GW      = dfsmg_pkg::CFG_DATA_W;
	localparam int DIM_MAX = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
	localparam int CMP_W   = $clog2(DIM_MAX + 64);

	// memory entry layout: {open, untried dirs, linked, parent y, parent x}
	localparam int PAR_W     = XW + YW;
	localparam int E_LINK    = PAR_W;
	localparam int E_DIRS_LO = PAR_W + 1;
	localparam int E_OPEN    = PAR_W + 1 + DW;
	localparam int ENTRY_W   = E_OPEN + 1;

	// sequencer states
	localparam logic [2:0] S_IDLE     = 3'd0;
	localparam logic [2:0] S_SWEEP    = 3'd1;
	localparam logic [2:0] S_READ     = 3'd2;
	localparam logic [2:0] S_CHK_CUR  = 3'd3;
	localparam logic [2:0] S_CHK_TGT  = 3'd4;
	localparam logic [2:0] S_OPEN_MID = 3'd5;
	localparam logic [2:0] S_RESULT   = 3'd6;

	function automatic logic [AW-1:0] cell_addr(input logic [YW-1:0] y, input logic [XW-1:0] x);
		cell_addr = AW'(AW'(y) * AW'(MAX_WIDTH) + AW'(x));
	endfunction

	// control state
	logic [2:0]      state_q;
	logic [GW-1:0]   grid_width_q;
	logic [GW-1:0]   grid_height_q;
	logic [XW-1:0]   cur_x_q;
	logic [YW-1:0]   cur_y_q;
	logic            done_q;
	logic            cells_valid_q;
	logic            out_valid_q;

	// working registers
	logic [XW-1:0]   sw_x_q;
	logic [YW-1:0]   sw_y_q;
	logic [AW-1:0]   sw_addr_q;
	logic [dfsmg_pkg::DIR_W-1:0] dir_q;
	logic            rd_inrange_q;
	logic [XW-1:0]   tgt_x_q;
	logic [YW-1:0]   tgt_y_q;
	logic [AW-1:0]   tgt_addr_q;
	logic [AW-1:0]   mid_addr_q;
	logic [SW-1:0]   res_status_q;
	logic            res_open_q;

	// output register payload
	logic [SW-1:0]   out_status_q;
	logic [CW-1:0]   out_x_q;
	logic [CW-1:0]   out_y_q;
	logic            out_open_q;
	logic            out_done_q;

	// memory port
	logic               ram_we;
	logic [AW-1:0]      ram_waddr;
	logic [ENTRY_W-1:0] ram_wdata;
	logic [AW-1:0]      ram_raddr;
	logic [ENTRY_W-1:0] rd_data;

	// derived values
	logic [CMP_W-1:0]   w_use;
	logic [CMP_W-1:0]   h_use;
	logic [AW-1:0]      cur_addr;
	logic [AW-1:0]      read_addr;
	logic               read_inrange;
	logic [DW-1:0]      rd_dirs;
	logic [DW-1:0]      dir_bit;
	logic               cur_at_start;
	logic               dir_untried;
	logic               move_ok;
	logic [CMP_W-1:0]   cx_e;
	logic [CMP_W-1:0]   cy_e;
	logic [CMP_W-1:0]   tgt_x_e;
	logic [CMP_W-1:0]   tgt_y_e;
	logic [CMP_W-1:0]   mid_x_e;
	logic [CMP_W-1:0]   mid_y_e;
	logic [XW-1:0]      tgt_x;
	logic [YW-1:0]      tgt_y;
	logic               sweep_node;
	logic               sweep_start;
	logic               sweep_last;
	logic               tgt_free;
	logic               accept;
	logic               out_free;
	logic               out_load;

	dfsmg_cell_ram #(
		.DEPTH  (CELLS),
		.ADDR_W (AW),
		.DATA_W (ENTRY_W)
	) u_cell_ram (
		.clk            (clk),
		.we             (ram_we),
		.waddr          (ram_waddr),
		.wdata          (ram_wdata),
		.raddr          (ram_raddr),
		.contents_valid (cells_valid_q),
		.rdata          (rd_data)
	);

	// clamp the grid size in use
	always_comb begin
		w_use = CMP_W'(grid_width_q);
		if (w_use < CMP_W'(dfsmg_pkg::GRID_DIM_MIN)) begin
			w_use = CMP_W'(dfsmg_pkg::GRID_DIM_MIN);
		end else if (w_use > CMP_W'(MAX_WIDTH)) begin
			w_use = CMP_W'(MAX_WIDTH);
		end
		h_use = CMP_W'(grid_height_q);
		if (h_use < CMP_W'(dfsmg_pkg::GRID_DIM_MIN)) begin
			h_use = CMP_W'(dfsmg_pkg::GRID_DIM_MIN);
		end else if (h_use > CMP_W'(MAX_HEIGHT)) begin
			h_use = CMP_W'(MAX_HEIGHT);
		end
	end

	assign accept   = items.valid && items.ready;
	assign out_free = !out_valid_q || results.ready;
	assign out_load = (state_q == S_RESULT) && out_free;
	assign items.ready = (state_q == S_IDLE);

	assign cur_addr     = cell_addr(cur_y_q, cur_x_q);
	assign cur_at_start = (cur_x_q == XW'(1)) && (cur_y_q == YW'(1));

	// read address of a cell read; cells beyond the array read as wall
	assign read_inrange = (CMP_W'(items.cell_x) < CMP_W'(MAX_WIDTH)) &&
		(CMP_W'(items.cell_y) < CMP_W'(MAX_HEIGHT));
	assign read_addr = read_inrange ?
		cell_addr(YW'(items.cell_y), XW'(items.cell_x)) : '0;

	// current node checks
	assign rd_dirs     = rd_data[E_DIRS_LO +: DW];
	assign dir_bit     = DW'(1) << dir_q;
	assign dir_untried = (rd_dirs & dir_bit) != '0;
	assign tgt_free    = rd_data[E_OPEN] && !rd_data[E_LINK];

	// neighbor two cells away and the wall between
	always_comb begin
		cx_e    = CMP_W'(cur_x_q);
		cy_e    = CMP_W'(cur_y_q);
		tgt_x_e = cx_e;
		tgt_y_e = cy_e;
		mid_x_e = cx_e;
		mid_y_e = cy_e;
		move_ok = 1'b0;
		case (dir_q)
			dfsmg_pkg::DIR_RIGHT: begin
				move_ok = (cx_e + CMP_W'(2)) < w_use;
				tgt_x_e = cx_e + CMP_W'(2);
				mid_x_e = cx_e + CMP_W'(1);
			end
			dfsmg_pkg::DIR_DOWN: begin
				move_ok = (cy_e + CMP_W'(2)) < h_use;
				tgt_y_e = cy_e + CMP_W'(2);
				mid_y_e = cy_e + CMP_W'(1);
			end
			dfsmg_pkg::DIR_LEFT: begin
				move_ok = cx_e >= CMP_W'(2);
				tgt_x_e = cx_e - CMP_W'(2);
				mid_x_e = cx_e - CMP_W'(1);
			end
			default: begin
				move_ok = cy_e >= CMP_W'(2);
				tgt_y_e = cy_e - CMP_W'(2);
				mid_y_e = cy_e - CMP_W'(1);
			end
		endcase
	end

	assign tgt_x = XW'(tgt_x_e);
	assign tgt_y = YW'(tgt_y_e);

	// init sweep: open cells with both coordinates odd inside the grid in use
	assign sweep_node = (CMP_W'(sw_x_q) < w_use) && (CMP_W'(sw_y_q) < h_use) &&
		sw_x_q[0] && sw_y_q[0];
	assign sweep_start = (sw_x_q == XW'(1)) && (sw_y_q == YW'(1));
	assign sweep_last  = (sw_x_q == XW'(MAX_WIDTH - 1)) && (sw_y_q == YW'(MAX_HEIGHT - 1));

	// drive the memory port
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = cur_addr;
		ram_wdata = '0;
		ram_raddr = cur_addr;
		case (state_q)
			S_IDLE: begin
				if (items.opcode == dfsmg_pkg::OP_READ) begin
					ram_raddr = read_addr;
				end
			end
			S_SWEEP: begin
				ram_we    = 1'b1;
				ram_waddr = sw_addr_q;
				if (sweep_node) begin
					ram_wdata = {1'b1, dfsmg_pkg::ALL_DIRS, sweep_start,
						sweep_start ? YW'(1) : YW'(0), sweep_start ? XW'(1) : XW'(0)};
				end
			end
			S_CHK_CUR: begin
				ram_raddr = cell_addr(tgt_y, tgt_x);
				if (!done_q && rd_dirs != '0 && dir_untried) begin
					ram_we    = 1'b1;
					ram_wdata = {rd_data[E_OPEN], rd_dirs & ~dir_bit, rd_data[E_LINK],
						rd_data[PAR_W-1:0]};
				end
			end
			S_CHK_TGT: begin
				ram_waddr = tgt_addr_q;
				if (tgt_free) begin
					ram_we    = 1'b1;
					ram_wdata = {1'b1, rd_dirs, 1'b1, cur_y_q, cur_x_q};
				end
			end
			S_OPEN_MID: begin
				ram_we    = 1'b1;
				ram_waddr = mid_addr_q;
				ram_wdata = {1'b1, DW'(0), 1'b0, PAR_W'(0)};
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_width_q  <= dfsmg_pkg::GRID_DIM_RESET;
			grid_height_q <= dfsmg_pkg::GRID_DIM_RESET;
		end else if (cfg_we) begin
			if (cfg_index == dfsmg_pkg::REG_GRID_WIDTH) begin
				grid_width_q <= cfg_wdata;
			end else begin
				grid_height_q <= cfg_wdata;
			end
		end
	end

	// sequencer and search state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			cur_x_q       <= XW'(1);
			cur_y_q       <= YW'(1);
			done_q        <= 1'b0;
			cells_valid_q <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			// raise the output transaction on load, drop it once taken
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						case (items.opcode)
							dfsmg_pkg::OP_INIT: begin
								cur_x_q       <= XW'(1);
								cur_y_q       <= YW'(1);
								done_q        <= 1'b0;
								cells_valid_q <= 1'b1;
								state_q       <= S_SWEEP;
							end
							dfsmg_pkg::OP_STEP: state_q <= S_CHK_CUR;
							dfsmg_pkg::OP_READ: state_q <= S_READ;
							default: state_q <= S_RESULT;
						endcase
					end
				end
				S_SWEEP: begin
					if (sweep_last) begin
						state_q <= S_RESULT;
					end
				end
				S_READ: state_q <= S_RESULT;
				S_CHK_CUR: begin
					if (done_q) begin
						state_q <= S_RESULT;
					end else if (rd_dirs == '0) begin
						// exhausted node: finish at the start, else back up to the parent
						if (cur_at_start) begin
							done_q <= 1'b1;
						end else begin
							cur_x_q <= rd_data[XW-1:0];
							cur_y_q <= rd_data[PAR_W-1:XW];
						end
						state_q <= S_RESULT;
					end else if (dir_untried && move_ok) begin
						state_q <= S_CHK_TGT;
					end else begin
						state_q <= S_RESULT;
					end
				end
				S_CHK_TGT: begin
					if (tgt_free) begin
						cur_x_q <= tgt_x_q;
						cur_y_q <= tgt_y_q;
						state_q <= S_OPEN_MID;
					end else begin
						state_q <= S_RESULT;
					end
				end
				S_OPEN_MID: state_q <= S_RESULT;
				S_RESULT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// working and result registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				dir_q        <= items.random_dir;
				rd_inrange_q <= read_inrange;
				sw_x_q       <= '0;
				sw_y_q       <= '0;
				sw_addr_q    <= '0;
				res_status_q <= dfsmg_pkg::STAT_ACK;
				res_open_q   <= 1'b0;
			end
			S_SWEEP: begin
				// advance the sweep in row order
				sw_addr_q <= sw_addr_q + AW'(1);
				if (sw_x_q == XW'(MAX_WIDTH - 1)) begin
					sw_x_q <= '0;
					sw_y_q <= sw_y_q + YW'(1);
				end else begin
					sw_x_q <= sw_x_q + XW'(1);
				end
			end
			S_READ: res_open_q <= rd_inrange_q && rd_data[E_OPEN];
			S_CHK_CUR: begin
				tgt_x_q    <= tgt_x;
				tgt_y_q    <= tgt_y;
				tgt_addr_q <= cell_addr(tgt_y, tgt_x);
				mid_addr_q <= cell_addr(YW'(mid_y_e), XW'(mid_x_e));
				if (done_q) begin
					res_status_q <= dfsmg_pkg::STAT_FINISHED;
				end else if (rd_dirs == '0) begin
					res_status_q <= cur_at_start ? dfsmg_pkg::STAT_FINISHED :
						dfsmg_pkg::STAT_BACKTRACK;
				end else begin
					res_status_q <= dfsmg_pkg::STAT_NO_MOVE;
				end
			end
			S_CHK_TGT: begin
				if (tgt_free) begin
					res_status_q <= dfsmg_pkg::STAT_ADVANCED;
				end
			end
			default: begin
				res_open_q <= res_open_q;
			end
		endcase
	end

	// load the output register
	always_ff @(posedge clk) begin
		if (out_load) begin
			out_status_q <= res_status_q;
			out_x_q      <= CW'(cur_x_q);
			out_y_q      <= CW'(cur_y_q);
			out_open_q   <= res_open_q;
			out_done_q   <= done_q;
		end
	end

	assign results.valid       = out_valid_q;
	assign results.step_status = out_status_q;
	assign results.current_x   = out_x_q;
	assign results.current_y   = out_y_q;
	assign results.cell_open   = out_open_q;
	assign results.maze_done   = out_done_q;

endmodule

/* bench/dfs_maze_generator_core_test.sv */
// Self-checking bench for the maze generator core: directed table, then random search phases.
`timescale 1ns / 1ps

module dfs_maze_generator_core_test;

	localparam int MAX_W = 32;
	localparam int MAX_H = 32;
	localparam int CELLS = MAX_W * MAX_H;
	localparam int IDX_W = $clog2(CELLS);
	localparam logic [IDX_W-1:0] START_CELL = IDX_W'(MAX_W + 1);
	localparam logic [dfsmg_pkg::OPCODE_W-1:0] OP_UNUSED = 2'd3;
	localparam int RANDOM_ITEMS = 1800;
	localparam int PHASE_CAP    = 350;
	localparam int LONG_HOLD    = 300;
	localparam int HOLD_SPACING = 700;
	localparam int STALL_LIMIT  = 20000;

	typedef struct packed {
		logic [dfsmg_pkg::OPCODE_W-1:0] opcode;
		logic [dfsmg_pkg::DIR_W-1:0]    dir;
		logic [dfsmg_pkg::COORD_W-1:0]  x;
		logic [dfsmg_pkg::COORD_W-1:0]  y;
	} maze_item_t;

	typedef struct packed {
		logic [dfsmg_pkg::STATUS_W-1:0] status;
		logic [dfsmg_pkg::COORD_W-1:0]  cur_x;
		logic [dfsmg_pkg::COORD_W-1:0]  cur_y;
		logic                           open;
		logic                           done;
	} maze_result_t;

	typedef enum logic {ROW_ITEM, ROW_WRITE} row_kind_t;

	typedef struct {
		row_kind_t                         kind;
		maze_item_t                        item;
		bit                                typed;
		maze_result_t                      want;
		logic [dfsmg_pkg::CFG_INDEX_W-1:0] reg_idx;
		logic [dfsmg_pkg::CFG_DATA_W-1:0]  reg_val;
	} plan_row_t;

	typedef enum logic [1:0] {RX_STEADY, RX_MOSTLY, RX_ALTERNATE, RX_SPARSE} rx_mode_t;

	logic                              clk;
	logic                              arst_n;
	logic                              cfg_we;
	logic [dfsmg_pkg::CFG_INDEX_W-1:0] cfg_index;
	logic [dfsmg_pkg::CFG_DATA_W-1:0]  cfg_wdata;

	dfsmg_item_if   item_bus ();
	dfsmg_result_if result_bus ();

	dfs_maze_generator_core #(
		.MAX_WIDTH(MAX_W),
		.MAX_HEIGHT(MAX_H)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.items(item_bus),
		.results(result_bus),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	// shadow copy of the maze and search state
	logic                             maze_open    [CELLS];
	logic [dfsmg_pkg::DIRS_W-1:0]     maze_untried [CELLS];
	logic [IDX_W-1:0]                 maze_parent  [CELLS];
	logic                             maze_linked  [CELLS];
	logic [IDX_W-1:0]                 maze_cur;
	logic                             maze_done;
	logic [dfsmg_pkg::CFG_DATA_W-1:0] maze_width;
	logic [dfsmg_pkg::CFG_DATA_W-1:0] maze_height;

	maze_result_t awaited_q[$];
	maze_result_t head_result;
	int           mismatches  = 0;
	int           idle_cycles = 0;
	int           burst_left  = 0;
	bit           sender_gaps = 1'b1;

	// clock: 10 ns period
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic int dim_in_use(logic [dfsmg_pkg::CFG_DATA_W-1:0] v, int maxv);
		if (int'(v) < dfsmg_pkg::GRID_DIM_MIN) return dfsmg_pkg::GRID_DIM_MIN;
		if (int'(v) > maxv) return maxv;
		return int'(v);
	endfunction

	// apply one item to the shadow maze and return the result it must produce
	function automatic maze_result_t maze_advance(maze_item_t it);
		maze_result_t r;
		int w, h, cx, cy, tx, ty, mx, my, t;
		logic [dfsmg_pkg::DIRS_W-1:0] mask;
		bit legal;
		r = '0;
		r.status = dfsmg_pkg::STAT_ACK;
		w = dim_in_use(maze_width, MAX_W);
		h = dim_in_use(maze_height, MAX_H);
		case (it.opcode)
		dfsmg_pkg::OP_INIT: begin
			for (int i = 0; i < CELLS; i++) begin
				cx = i % MAX_W;
				cy = i / MAX_W;
				legal = cx < w && cy < h && (cx % 2 == 1) && (cy % 2 == 1);
				maze_open[i]    = legal;
				maze_untried[i] = legal ? dfsmg_pkg::ALL_DIRS : '0;
				maze_parent[i]  = '0;
				maze_linked[i]  = 1'b0;
			end
			maze_cur = START_CELL;
			maze_parent[START_CELL] = START_CELL;
			maze_linked[START_CELL] = 1'b1;
			maze_done = 1'b0;
		end
		dfsmg_pkg::OP_STEP: begin
			cx = maze_cur % MAX_W;
			cy = maze_cur / MAX_W;
			mask = dfsmg_pkg::DIRS_W'(1) << it.dir;
			if (maze_done) begin
				r.status = dfsmg_pkg::STAT_FINISHED;
			end else if (maze_untried[maze_cur] == '0) begin
				// exhausted node: finish at the start, else back up to the parent
				if (maze_cur == START_CELL) begin
					maze_done = 1'b1;
					r.status = dfsmg_pkg::STAT_FINISHED;
				end else begin
					maze_cur = maze_parent[maze_cur];
					r.status = dfsmg_pkg::STAT_BACKTRACK;
				end
			end else if ((maze_untried[maze_cur] & mask) == '0) begin
				r.status = dfsmg_pkg::STAT_NO_MOVE;
			end else begin
				maze_untried[maze_cur] = maze_untried[maze_cur] & ~mask;
				tx = cx;
				ty = cy;
				mx = cx;
				my = cy;
				case (it.dir)
				dfsmg_pkg::DIR_RIGHT: begin
					legal = cx + 2 < w;
					tx = cx + 2;
					mx = cx + 1;
				end
				dfsmg_pkg::DIR_DOWN: begin
					legal = cy + 2 < h;
					ty = cy + 2;
					my = cy + 1;
				end
				dfsmg_pkg::DIR_LEFT: begin
					legal = cx >= 2;
					tx = cx - 2;
					mx = cx - 1;
				end
				default: begin
					legal = cy >= 2;
					ty = cy - 2;
					my = cy - 1;
				end
				endcase
				t = ty * MAX_W + tx;
				if (legal) begin
					legal = maze_open[t] && !maze_linked[t];
				end
				if (legal) begin
					maze_parent[t] = maze_cur;
					maze_linked[t] = 1'b1;
					maze_open[my * MAX_W + mx] = 1'b1;
					maze_cur = IDX_W'(t);
					r.status = dfsmg_pkg::STAT_ADVANCED;
				end else begin
					r.status = dfsmg_pkg::STAT_NO_MOVE;
				end
			end
		end
		dfsmg_pkg::OP_READ: begin
			r.open = maze_open[it.y * MAX_W + it.x];
		end
		default: begin
		end
		endcase
		r.cur_x = dfsmg_pkg::COORD_W'(maze_cur % MAX_W);
		r.cur_y = dfsmg_pkg::COORD_W'(maze_cur / MAX_W);
		r.done  = maze_done;
		return r;
	endfunction

	function automatic plan_row_t free_row(logic [dfsmg_pkg::OPCODE_W-1:0] op,
			logic [dfsmg_pkg::DIR_W-1:0] dir, int x, int y);
		plan_row_t row;
		row.kind        = ROW_ITEM;
		row.item.opcode = op;
		row.item.dir    = dir;
		row.item.x      = dfsmg_pkg::COORD_W'(x);
		row.item.y      = dfsmg_pkg::COORD_W'(y);
		row.typed       = 1'b0;
		row.want        = '0;
		row.reg_idx     = '0;
		row.reg_val     = '0;
		return row;
	endfunction

	function automatic plan_row_t typed_row(logic [dfsmg_pkg::OPCODE_W-1:0] op,
			logic [dfsmg_pkg::DIR_W-1:0] dir, int x, int y,
			logic [dfsmg_pkg::STATUS_W-1:0] st, int wx, int wy, bit open, bit done);
		plan_row_t row;
		row = free_row(op, dir, x, y);
		row.typed       = 1'b1;
		row.want.status = st;
		row.want.cur_x  = dfsmg_pkg::COORD_W'(wx);
		row.want.cur_y  = dfsmg_pkg::COORD_W'(wy);
		row.want.open   = open;
		row.want.done   = done;
		return row;
	endfunction

	function automatic plan_row_t reg_row(logic [dfsmg_pkg::CFG_INDEX_W-1:0] idx,
			logic [dfsmg_pkg::CFG_DATA_W-1:0] val);
		plan_row_t row;
		row = free_row(dfsmg_pkg::OP_INIT, dfsmg_pkg::DIR_RIGHT, 0, 0);
		row.kind    = ROW_WRITE;
		row.reg_idx = idx;
		row.reg_val = val;
		return row;
	endfunction

	function automatic maze_item_t rand_item(logic [dfsmg_pkg::OPCODE_W-1:0] op,
			logic [dfsmg_pkg::DIR_W-1:0] dir);
		maze_item_t it;
		it.opcode = op;
		it.dir    = dir;
		it.x      = dfsmg_pkg::COORD_W'($urandom_range(0, 31));
		it.y      = dfsmg_pkg::COORD_W'($urandom_range(0, 31));
		return it;
	endfunction

	// lean toward directions still untried at the current node
	function automatic logic [dfsmg_pkg::DIR_W-1:0] pick_dir();
		logic [dfsmg_pkg::DIRS_W-1:0] left;
		int d;
		left = maze_untried[maze_cur];
		d = $urandom_range(0, 3);
		if (left != '0 && $urandom_range(0, 9) < 6) begin
			while (!left[d]) d = (d + 1) % 4;
		end
		return dfsmg_pkg::DIR_W'(d);
	endfunction

	// mostly small odd grids, sometimes any value, rarely the largest
	function automatic logic [dfsmg_pkg::CFG_DATA_W-1:0] pick_dim();
		int r;
		r = $urandom_range(0, 19);
		if (r < 12) return dfsmg_pkg::CFG_DATA_W'(3 + 2 * $urandom_range(0, 4));
		if (r < 15) return dfsmg_pkg::CFG_DATA_W'($urandom_range(0, 20));
		if (r < 17) return dfsmg_pkg::CFG_DATA_W'($urandom_range(0, 63));
		if (r < 19) begin
			return $urandom_range(0, 1) ? dfsmg_pkg::CFG_DATA_W'(0) :
				dfsmg_pkg::CFG_DATA_W'(63);
		end
		return dfsmg_pkg::CFG_DATA_W'($urandom_range(30, 33));
	endfunction

	// offer one item in bursts with random gaps; predict it once accepted
	task automatic offer(maze_item_t it, bit typed, maze_result_t typed_want);
		int gap;
		maze_result_t predicted;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			gap = sender_gaps ? $urandom_range(0, 6) : 0;
			if (gap > 0) begin
				item_bus.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		item_bus.valid      <= 1'b1;
		item_bus.opcode     <= it.opcode;
		item_bus.random_dir <= it.dir;
		item_bus.cell_x     <= it.x;
		item_bus.cell_y     <= it.y;
		do @(posedge clk); while (!item_bus.ready);
		predicted = maze_advance(it);
		awaited_q.push_back(typed ? typed_want : predicted);
	endtask

	// drop valid and wait until every result is back
	task automatic settle();
		item_bus.valid <= 1'b0;
		burst_left = 0;
		while (awaited_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(logic [dfsmg_pkg::CFG_INDEX_W-1:0] idx,
			logic [dfsmg_pkg::CFG_DATA_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		if (idx == dfsmg_pkg::REG_GRID_WIDTH) begin
			maze_width = val;
		end else begin
			maze_height = val;
		end
	endtask

	task automatic check_field(string name, int want, int got);
		if (want != got) begin
			mismatches++;
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
		end
	endtask

	// compare each result transaction with the oldest prediction
	always @(posedge clk) begin
		if (arst_n && result_bus.valid && result_bus.ready) begin
			if (awaited_q.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected result, expected none, actual status %0d at (%0d,%0d)",
					$time, result_bus.step_status, result_bus.current_x, result_bus.current_y);
			end else begin
				head_result = awaited_q.pop_front();
				check_field("step_status", head_result.status, result_bus.step_status);
				check_field("current_x", head_result.cur_x, result_bus.current_x);
				check_field("current_y", head_result.cur_y, result_bus.current_y);
				check_field("cell_open", head_result.open, result_bus.cell_open);
				check_field("maze_done", head_result.done, result_bus.maze_done);
			end
		end
	end

	// end the run when no transaction moves for too long
	always @(posedge clk) begin
		if ((item_bus.valid && item_bus.ready) || (result_bus.valid && result_bus.ready)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
		end
		if (idle_cycles >= STALL_LIMIT) begin
			$display("%0t: no transaction for %0d cycles", $time, idle_cycles);
			$display("[dfs_maze_generator_core] ERROR");
			$finish;
		end
	end

	// result receiver: changing stall patterns plus a few long hold-offs
	initial begin : receiver
		rx_mode_t mode;
		int mode_left, hold_left, hold_mark, taken;
		bit flip, ready_next;
		mode       = RX_STEADY;
		mode_left  = 0;
		hold_left  = 0;
		hold_mark  = 400;
		taken      = 0;
		flip       = 1'b0;
		ready_next = 1'b0;
		result_bus.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (result_bus.valid && result_bus.ready) taken++;
			if (hold_left > 0) begin
				hold_left--;
				ready_next = 1'b0;
			end else if (taken >= hold_mark) begin
				hold_left = LONG_HOLD - 1;
				hold_mark += HOLD_SPACING;
				ready_next = 1'b0;
			end else begin
				if (mode_left == 0) begin
					mode = rx_mode_t'($urandom_range(0, 3));
					mode_left = $urandom_range(16, 160);
				end
				mode_left--;
				flip = ~flip;
				case (mode)
				RX_STEADY: ready_next = 1'b1;
				RX_MOSTLY: ready_next = $urandom_range(0, 3) != 0;
				RX_ALTERNATE: ready_next = flip;
				default: ready_next = $urandom_range(0, 3) == 0;
				endcase
			end
			result_bus.ready <= ready_next;
		end
	end

	initial begin : stimulus
		plan_row_t plan[$];
		maze_item_t it;
		int sent, extra, roll, n;
		arst_n              = 1'b0;
		cfg_we              = 1'b0;
		cfg_index           = '0;
		cfg_wdata           = '0;
		item_bus.valid      = 1'b0;
		item_bus.opcode     = '0;
		item_bus.random_dir = '0;
		item_bus.cell_x     = '0;
		item_bus.cell_y     = '0;

		// shadow state after reset
		for (int i = 0; i < CELLS; i++) begin
			maze_open[i]    = 1'b0;
			maze_untried[i] = '0;
			maze_parent[i]  = '0;
			maze_linked[i]  = 1'b0;
		end
		maze_cur    = START_CELL;
		maze_done   = 1'b0;
		maze_width  = dfsmg_pkg::GRID_DIM_RESET;
		maze_height = dfsmg_pkg::GRID_DIM_RESET;

		// before any init: all walls, start exhausted, so a step finishes
		plan.push_back(typed_row(dfsmg_pkg::OP_READ, dfsmg_pkg::DIR_RIGHT, 1, 1,
			dfsmg_pkg::STAT_ACK, 1, 1, 0, 0));
		plan.push_back(typed_row(OP_UNUSED, dfsmg_pkg::DIR_UP, 31, 31,
			dfsmg_pkg::STAT_ACK, 1, 1, 0, 0));
		plan.push_back(typed_row(dfsmg_pkg::OP_STEP, dfsmg_pkg::DIR_RIGHT, 0, 0,
			dfsmg_pkg::STAT_FINISHED, 1, 1, 0, 1));
		plan.push_back(typed_row(dfsmg_pkg::OP_STEP, dfsmg_pkg::DIR_UP, 31, 31,
			dfsmg_pkg::STAT_FINISHED, 1, 1, 0, 1));
		// out-of-range registers: width saturates to 3, height to 32
		plan.push_back(reg_row(dfsmg_pkg::REG_GRID_WIDTH, 6'd0));
		plan.push_back(reg_row(dfsmg_pkg::REG_GRID_HEIGHT, 6'd63));
		plan.push_back(typed_row(dfsmg_pkg::OP_INIT, dfsmg_pkg::DIR_LEFT, 31, 0,
			dfsmg_pkg::STAT_ACK, 1, 1, 0, 0));
		plan.push_back(typed_row(dfsmg_pkg::OP_READ, dfsmg_pkg::DIR_DOWN, 1, 1,
			dfsmg_pkg::STAT_ACK, 1, 1, 1, 0));
		plan.push_back(typed_row(dfsmg_pkg::OP_READ, dfsmg_pkg::DIR_UP, 31, 31,
			dfsmg_pkg::STAT_ACK, 1, 1, 0, 0));
		plan.push_back(typed_row(dfsmg_pkg::OP_READ, dfsmg_pkg::DIR_RIGHT, 0, 0,
			dfsmg_pkg::STAT_ACK, 1, 1, 0, 0));
		// blocked at the right edge, then the same direction already tried
		plan.push_back(typed_row(dfsmg_pkg::OP_STEP, dfsmg_pkg::DIR_RIGHT, 0, 0,
			dfsmg_pkg::STAT_NO_MOVE, 1, 1, 0, 0));
		plan.push_back(typed_row(dfsmg_pkg::OP_STEP, dfsmg_pkg::DIR_RIGHT, 31, 31,
			dfsmg_pkg::STAT_NO_MOVE, 1, 1, 0, 0));
		plan.push_back(typed_row(dfsmg_pkg::OP_STEP, dfsmg_pkg::DIR_LEFT, 0, 31,
			dfsmg_pkg::STAT_NO_MOVE, 1, 1, 0, 0));
		plan.push_back(typed_row(dfsmg_pkg::OP_STEP, dfsmg_pkg::DIR_UP, 31, 0,
			dfsmg_pkg::STAT_NO_MOVE, 1, 1, 0, 0));
		plan.push_back(typed_row(dfsmg_pkg::OP_STEP, dfsmg_pkg::DIR_DOWN, 0, 0,
			dfsmg_pkg::STAT_ADVANCED, 1, 3, 0, 0));
		plan.push_back(typed_row(dfsmg_pkg::OP_READ, dfsmg_pkg::DIR_LEFT, 1, 2,
			dfsmg_pkg::STAT_ACK, 1, 3, 1, 0));
		// back toward the linked start is blocked
		plan.push_back(typed_row(dfsmg_pkg::OP_STEP, dfsmg_pkg::DIR_UP, 0, 0,
			dfsmg_pkg::STAT_NO_MOVE, 1, 3, 0, 0));
		plan.push_back(free_row(dfsmg_pkg::OP_STEP, dfsmg_pkg::DIR_DOWN, 7, 9));
		plan.push_back(free_row(dfsmg_pkg::OP_STEP, dfsmg_pkg::DIR_DOWN, 21, 14));
		// smallest grid: every direction blocked, then finish at the start
		plan.push_back(reg_row(dfsmg_pkg::REG_GRID_WIDTH, 6'd3));
		plan.push_back(reg_row(dfsmg_pkg::REG_GRID_HEIGHT, 6'd3));
		plan.push_back(typed_row(dfsmg_pkg::OP_INIT, dfsmg_pkg::DIR_DOWN, 0, 0,
			dfsmg_pkg::STAT_ACK, 1, 1, 0, 0));
		plan.push_back(typed_row(dfsmg_pkg::OP_STEP, dfsmg_pkg::DIR_DOWN, 0, 0,
			dfsmg_pkg::STAT_NO_MOVE, 1, 1, 0, 0));
		plan.push_back(typed_row(dfsmg_pkg::OP_STEP, dfsmg_pkg::DIR_RIGHT, 0, 0,
			dfsmg_pkg::STAT_NO_MOVE, 1, 1, 0, 0));
		plan.push_back(typed_row(dfsmg_pkg::OP_STEP, dfsmg_pkg::DIR_LEFT, 0, 0,
			dfsmg_pkg::STAT_NO_MOVE, 1, 1, 0, 0));
		plan.push_back(typed_row(dfsmg_pkg::OP_STEP, dfsmg_pkg::DIR_UP, 0, 0,
			dfsmg_pkg::STAT_NO_MOVE, 1, 1, 0, 0));
		plan.push_back(typed_row(dfsmg_pkg::OP_STEP, dfsmg_pkg::DIR_RIGHT, 0, 0,
			dfsmg_pkg::STAT_FINISHED, 1, 1, 0, 1));
		plan.push_back(typed_row(dfsmg_pkg::OP_STEP, dfsmg_pkg::DIR_LEFT, 0, 0,
			dfsmg_pkg::STAT_FINISHED, 1, 1, 0, 1));

		// hold reset, then release it
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// walk the directed table
		foreach (plan[k]) begin
			if (plan[k].kind == ROW_WRITE) begin
				settle();
				write_reg(plan[k].reg_idx, plan[k].reg_val);
			end else begin
				offer(plan[k].item, plan[k].typed, plan[k].want);
			end
		end

		// random phases: new grid size, init, then a search with reads and noise
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			settle();
			if ($urandom_range(0, 3) != 0) write_reg(dfsmg_pkg::REG_GRID_WIDTH, pick_dim());
			if ($urandom_range(0, 3) != 0) write_reg(dfsmg_pkg::REG_GRID_HEIGHT, pick_dim());
			sender_gaps = $urandom_range(0, 3) != 0;
			// now and then keep the old maze under the new bounds
			if ($urandom_range(0, 5) != 0) begin
				offer(rand_item(dfsmg_pkg::OP_INIT, dfsmg_pkg::DIR_W'($urandom_range(0, 3))),
					1'b0, '0);
				sent++;
			end
			extra = $urandom_range(1, 4);
			n = 0;
			while (n < PHASE_CAP && sent < RANDOM_ITEMS && extra > 0) begin
				roll = $urandom_range(0, 99);
				if (roll < 80) begin
					it = rand_item(dfsmg_pkg::OP_STEP, pick_dir());
				end else if (roll < 93) begin
					it = rand_item(dfsmg_pkg::OP_READ, dfsmg_pkg::DIR_W'($urandom_range(0, 3)));
					if (roll < 87) begin
						it.x = dfsmg_pkg::COORD_W'(maze_cur % MAX_W + $urandom_range(0, 2) - 1);
						it.y = dfsmg_pkg::COORD_W'(maze_cur / MAX_W + $urandom_range(0, 2) - 1);
					end
				end else if (roll < 97) begin
					it = rand_item(OP_UNUSED, dfsmg_pkg::DIR_W'($urandom_range(0, 3)));
				end else begin
					// restart in the middle of a search
					it = rand_item(dfsmg_pkg::OP_INIT, dfsmg_pkg::DIR_W'($urandom_range(0, 3)));
				end
				offer(it, 1'b0, '0);
				if (it.opcode != OP_UNUSED) sent++;
				n++;
				if (maze_done) extra--;
			end
		end

		// drain and let any stray result show up
		settle();
		repeat (16) @(posedge clk);
		if (mismatches == 0) begin
			$display("[dfs_maze_generator_core] OK");
		end else begin
			$display("[dfs_maze_generator_core] ERROR");
		end
		$finish;
	end

endmodule
